// ===== src/text_line_folder_assert.svh =====
// assertion macros for the checker file
// needs signals named clock and reset in the scope of use
`ifndef TEXT_LINE_FOLDER_ASSERT_SVH
`define TEXT_LINE_FOLDER_ASSERT_SVH

// condition holds in the same cycle
`define TLF_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed");

// condition holds in the following cycle
`define TLF_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ===== src/tlf_pkg.sv =====
// shared constants and types for the text line folder
// no dependencies
package tlf_pkg;

   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_NL    = 8'd10;
   localparam logic [7:0] CH_BLANK = 8'd32;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_TAB   = 6'b000010,
      ST_SCAN  = 6'b000100,
      ST_SEND  = 6'b001000,
      ST_NLOUT = 6'b010000,
      ST_SHIFT = 6'b100000
   } state_type;

endpackage

// ===== src/tlf_if.sv =====
// valid/ready channel interfaces for the text line folder
// no dependencies
interface tlf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface tlf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink (input valid, input out_byte, input last, output ready);
endinterface

// ===== src/tlf_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module tlf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 10
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== src/text_line_folder.sv =====
// text line folder: takes one byte per transaction and folds the text into lines of at
// most LINE_WIDTH bytes, expanding tabs to TAB_WIDTH stops and dropping empty lines. A
// non-blank byte that fills the line starts a backward blank scan over the line ram,
// then the line goes out one byte per cycle while the receiver is ready, plus a newline,
// and the remainder is copied to the front at one byte per cycle. Input is taken only
// in the idle state, not while a tab is expanded or a line is scanned, sent or moved.
// depends on tlf_pkg, tlf_if, tlf_ram
module text_line_folder import tlf_pkg::*; #(
   parameter int LINE_WIDTH = 10,
   parameter int TAB_WIDTH  = 8
) (
   input  logic      clock,
   input  logic      reset,
   tlf_req_if.sink   req_chan,
   tlf_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(LINE_WIDTH);
   localparam int CW = $clog2(LINE_WIDTH + 1);
   localparam int MW = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
   localparam logic [AW-1:0] LAST_IDX   = AW'(LINE_WIDTH - 1);
   localparam logic [AW-1:0] SCAN_START = AW'(LINE_WIDTH - 2);
   localparam logic [CW-1:0] FULL_CNT   = CW'(LINE_WIDTH);
   localparam logic [MW-1:0] TAB_LAST   = MW'(TAB_WIDTH - 1);

   state_type     state_ff, state_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [MW-1:0] mod_ff, mod_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] src_ff, src_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          shift_ff, shift_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;

   logic [CW-1:0] pos_inc;
   logic [MW-1:0] mod_inc;
   logic          req_fire;
   logic          rsp_fire;

   tlf_ram #(.WIDTH(8), .DEPTH(LINE_WIDTH)) u_line_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign rsp_chan.valid    = (state_ff == ST_SEND) || (state_ff == ST_NLOUT);
   assign rsp_chan.out_byte = (state_ff == ST_SEND) ? ram_rdata : CH_NL;
   assign rsp_chan.last     = (state_ff == ST_NLOUT);

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign pos_inc  = CW'(pos_ff) + CW'(1);
   assign mod_inc  = (mod_ff == TAB_LAST) ? '0 : mod_ff + MW'(1);

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      mod_in    = mod_ff;
      idx_in    = idx_ff;
      src_in    = src_ff;
      cnt_in    = cnt_ff;
      shift_in  = shift_ff;
      ram_we    = 1'b0;
      ram_waddr = pos_ff;
      ram_wdata = CH_BLANK;
      ram_raddr = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_chan.in_byte)
                  CH_TAB: begin
                     state_in = ST_TAB;
                  end
                  CH_NL: begin
                     if (pos_ff != '0) begin
                        cnt_in   = CW'(pos_ff);
                        shift_in = 1'b0;
                        idx_in   = '0;
                        pos_in   = '0;
                        mod_in   = '0;
                        state_in = ST_SEND;
                     end
                  end
                  default: begin
                     ram_we    = 1'b1;
                     ram_wdata = req_chan.in_byte;
                     if (pos_ff == LAST_IDX) begin
                        if (req_chan.in_byte == CH_BLANK) begin
                           cnt_in   = FULL_CNT;
                           shift_in = 1'b0;
                           idx_in   = '0;
                           pos_in   = '0;
                           mod_in   = '0;
                           state_in = ST_SEND;
                        end else begin
                           src_in    = SCAN_START;
                           ram_raddr = SCAN_START;
                           state_in  = ST_SCAN;
                        end
                     end else begin
                        pos_in = pos_inc[AW-1:0];
                        mod_in = mod_inc;
                     end
                  end
               endcase
            end
         end
         ST_TAB: begin
            ram_we = 1'b1;
            if (pos_inc == FULL_CNT) begin
               cnt_in   = FULL_CNT;
               shift_in = 1'b0;
               idx_in   = '0;
               pos_in   = '0;
               mod_in   = '0;
               state_in = ST_SEND;
            end else begin
               pos_in = pos_inc[AW-1:0];
               mod_in = mod_inc;
               if (mod_inc == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCAN: begin
            if (src_ff == '0) begin
               cnt_in   = FULL_CNT;
               shift_in = 1'b0;
               idx_in   = '0;
               pos_in   = '0;
               mod_in   = '0;
               state_in = ST_SEND;
            end else if (ram_rdata == CH_BLANK) begin
               cnt_in   = CW'(src_ff) + CW'(1);
               src_in   = src_ff + AW'(1);
               shift_in = 1'b1;
               idx_in   = '0;
               pos_in   = '0;
               mod_in   = '0;
               state_in = ST_SEND;
            end else begin
               src_in    = src_ff - AW'(1);
               ram_raddr = src_ff - AW'(1);
            end
         end
         ST_SEND: begin
            ram_raddr = idx_ff;
            if (rsp_fire) begin
               ram_raddr = idx_ff + AW'(1);
               idx_in    = idx_ff + AW'(1);
               if (CW'(idx_ff) + CW'(1) == cnt_ff) begin
                  state_in = ST_NLOUT;
               end
            end
         end
         ST_NLOUT: begin
            if (rsp_fire) begin
               if (shift_ff) begin
                  ram_raddr = src_ff;
                  state_in  = ST_SHIFT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SHIFT: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            pos_in    = pos_inc[AW-1:0];
            mod_in    = mod_inc;
            src_in    = src_ff + AW'(1);
            ram_raddr = src_ff + AW'(1);
            if (src_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         mod_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         mod_ff   <= mod_in;
      end
      idx_ff   <= idx_in;
      src_ff   <= src_in;
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
   end

endmodule

// ===== src/tlf_checker.sv =====
// port-level checks for the text line folder, bound to the top level
// depends on tlf_pkg and text_line_folder_assert.svh
`include "text_line_folder_assert.svh"

module tlf_checker import tlf_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last
);

   // no new input while a line is going out
   `TLF_ASSERT_NOW(a_no_req_during_rsp, rsp_valid, !req_ready)
   // every output line ends in a newline and only there
   `TLF_ASSERT_NOW(a_last_is_newline, rsp_valid && rsp_last, rsp_out_byte == CH_NL)
   `TLF_ASSERT_NOW(a_newline_is_last, rsp_valid && !rsp_last, rsp_out_byte != CH_NL)
   // a stalled transaction holds
   `TLF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))
   // the line ends after its newline goes out
   `TLF_ASSERT_NEXT(a_gap_after_last, rsp_valid && rsp_ready && rsp_last, !rsp_valid)

endmodule

bind text_line_folder tlf_checker u_tlf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_out_byte (rsp_chan.out_byte),
   .rsp_last     (rsp_chan.last)
);

// ===== sim/testbench.sv =====
// testbench for text_line_folder: folds a text stream and checks every emitted byte
// against typed text or a behavioral folder kept in step with each accepted transaction
// depends on tlf_pkg, tlf_if and the text_line_folder rtl
module testbench import tlf_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_W = 10;
   localparam int TAB_W = 8;
   localparam int DIR_ROWS = 25;
   localparam int RAND_PER_PHASE = 59;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tlf_req_if req_chan();
   tlf_rsp_if rsp_chan();

   text_line_folder #(
      .LINE_WIDTH(LINE_W),
      .TAB_WIDTH(TAB_W)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always #5 clock = ~clock;

   // directed rows: empty newline, tabs up to the width, extreme bytes with a blank
   // in the last slot, a blank only at the front, then a short line
   logic [7:0] dir_byte [DIR_ROWS] = '{
      CH_NL, CH_TAB, CH_TAB,
      8'h00, 8'hFF, 8'h01, "A", "B", 8'h7F, "C", 8'h80, "D", CH_BLANK,
      CH_BLANK, "a", "b", "c", "d", "e", "f", "g", "h", "i",
      "q", CH_NL
   };
   bit dir_typed [DIR_ROWS] = '{
      1, 1, 1,
      0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
      0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
      0, 1
   };
   string dir_text [DIR_ROWS] = '{
      "", "", "          \n",
      "", "", "", "", "", "", "", "", "", "",
      "", "", "", "", "", "", "", "", "", " abcdefghi\n",
      "", "q\n"
   };

   logic [7:0] line_buf [LINE_W];
   int fill_pos;
   logic [7:0] line_bytes [$];

   logic [7:0] exp_byte [$];
   bit exp_last [$];

   int send_gap_pct;
   int stall_pct;
   int errors;
   int xfer_in;
   int bytes_out;
   int lines_out;
   logic [7:0] want_byte;
   bit want_last;

   function automatic void put_line(input int n);
      for (int i = 0; i < n; i++)
         line_bytes.push_back(line_buf[i]);
      if (n > 0)
         line_bytes.push_back(CH_NL);
   endfunction

   function automatic void fold_byte(input logic [7:0] ch);
      int p;
      int cut;
      line_bytes = {};
      if (ch == CH_TAB) begin
         do begin
            line_buf[fill_pos] = CH_BLANK;
            fill_pos++;
         end while (fill_pos < LINE_W && fill_pos % TAB_W != 0);
         if (fill_pos >= LINE_W) begin
            put_line(LINE_W);
            fill_pos = 0;
         end
      end else if (ch == CH_NL) begin
         put_line(fill_pos);
         fill_pos = 0;
      end else begin
         line_buf[fill_pos] = ch;
         fill_pos++;
         if (fill_pos >= LINE_W) begin
            p = LINE_W - 1;
            while (p > 0 && line_buf[p] != CH_BLANK)
               p--;
            cut = (p == 0) ? LINE_W : p + 1;
            put_line(cut);
            fill_pos = LINE_W - cut;
            for (int i = 0; i < fill_pos; i++)
               line_buf[i] = line_buf[cut + i];
         end
      end
   endfunction

   // mostly words and blanks, some tabs and newlines, the rest any byte
   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 8'($urandom_range(8'h61, 8'h7A));
      else if (r < 75)
         return CH_BLANK;
      else if (r < 83)
         return CH_TAB;
      else if (r < 91)
         return CH_NL;
      else
         return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_char(input logic [7:0] ch, input bit typed, input string text);
      while (send_gap_pct > 0 && $urandom_range(1, 100) <= send_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.in_byte <= ch;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      xfer_in++;
      fold_byte(ch);
      if (typed) begin
         line_bytes = {};
         for (int i = 0; i < text.len(); i++)
            line_bytes.push_back(text[i]);
      end
      foreach (line_bytes[i]) begin
         exp_byte.push_back(line_bytes[i]);
         exp_last.push_back(i == line_bytes.size() - 1);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         bytes_out++;
         if (exp_byte.size() == 0) begin
            $display("%0t: unexpected transaction out_byte %h last %b",
                     $time, rsp_chan.out_byte, rsp_chan.last);
            errors++;
         end else begin
            want_byte = exp_byte.pop_front();
            want_last = exp_last.pop_front();
            if (want_byte == CH_NL)
               lines_out++;
            if (rsp_chan.out_byte !== want_byte || rsp_chan.last !== want_last) begin
               $display("%0t: expected out_byte %h last %b, got out_byte %h last %b",
                        $time, want_byte, want_last, rsp_chan.out_byte, rsp_chan.last);
               errors++;
            end
         end
      end
      rsp_chan.ready <= (stall_pct == 0) || ($urandom_range(1, 100) > stall_pct);
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.in_byte = 8'h00;
      rsp_chan.ready = 1'b0;
      send_gap_pct = 0;
      stall_pct = 0;
      errors = 0;
      xfer_in = 0;
      bytes_out = 0;
      lines_out = 0;
      fill_pos = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int row = 0; row < DIR_ROWS; row++)
         send_char(dir_byte[row], dir_typed[row], dir_text[row]);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 47; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 47; end
            default: begin send_gap_pct = 19; stall_pct = 19; end
         endcase
         repeat (RAND_PER_PHASE)
            send_char(pick_char(), 1'b0, "");
      end
      req_chan.valid <= 1'b0;

      while (exp_byte.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      $display("folded %0d input transactions into %0d output bytes over %0d lines,",
               xfer_in, bytes_out, lines_out);
      $display("with sender gaps and receiver stalls in separate and combined phases");
      if (errors == 0 && exp_byte.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #5ms;
      $display("timeout with %0d transactions still expected", exp_byte.size());
      $display("status: fail");
      $finish;
   end

endmodule

// ===== text_line_folder.f =====
+incdir+src
src/tlf_pkg.sv
src/tlf_if.sv
src/tlf_ram.sv
src/text_line_folder.sv
src/tlf_checker.sv
sim/testbench.sv
